// ===== src/json_token_lexer_assert.svh =====
// Assertion macros shared by the JSON token lexer RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef JSON_TOKEN_LEXER_ASSERT_SVH
`define JSON_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/jtl_pkg.sv =====
// Types, codes and character constants for the JSON token lexer.
// No dependencies; used by jtl_step, jtl_out_stage and json_token_lexer.
package jtl_pkg;

  localparam int LEN_W = 16;

  // Token kinds carried in the mode field
  localparam logic [2:0] MODE_STRING = 3'd0;
  localparam logic [2:0] MODE_NUMBER = 3'd1;
  localparam logic [2:0] MODE_SYNTAX = 3'd2;
  localparam logic [2:0] MODE_NULL   = 3'd3;
  localparam logic [2:0] MODE_TRUE   = 3'd4;
  localparam logic [2:0] MODE_FALSE  = 3'd5;

  // Token end status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_MATCH   = 3'd1;
  localparam logic [2:0] ST_KW_PARTIAL = 3'd2;
  localparam logic [2:0] ST_EOF_ESC    = 3'd3;
  localparam logic [2:0] ST_SHORT_UNI  = 3'd4;
  localparam logic [2:0] ST_BAD_ESC    = 3'd5;
  localparam logic [2:0] ST_UNTERM     = 3'd6;

  localparam logic [2:0] UNI_SKIP = 3'd4;

  // Characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [12:0] {
    PH_IDLE      = 13'b0000000000001,
    PH_STR_BODY  = 13'b0000000000010,
    PH_STR_ESC   = 13'b0000000000100,
    PH_STR_UHEX  = 13'b0000000001000,
    PH_STR_UEND  = 13'b0000000010000,
    PH_STR_OPEN  = 13'b0000000100000,
    PH_NUM_START = 13'b0000001000000,
    PH_NUM_INT   = 13'b0000010000000,
    PH_NUM_FRAC  = 13'b0000100000000,
    PH_NUM_EXPS  = 13'b0001000000000,
    PH_NUM_EXPD  = 13'b0010000000000,
    PH_SYNTAX    = 13'b0100000000000,
    PH_KEYWORD   = 13'b1000000000000
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [2:0]         kind;
    logic [2:0]         kw_pos;
    logic [2:0]         uni_left;
    logic               digit_seen;
    logic [LEN_W-1:0]   len;
  } lex_state_t;

  typedef struct packed {
    logic               value_valid;
    logic [7:0]         value_byte;
    logic               consumed;
    logic               token_end;
    logic [LEN_W-1:0]   token_length;
    logic [2:0]         status;
  } lex_result_t;

  // Expected keyword character at a match position
  function automatic logic [7:0] kw_char(input logic [2:0] kind, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (kind)
      MODE_NULL: begin
        case (pos)
          3'd0: ch = 8'h6E;
          3'd1: ch = 8'h75;
          3'd2: ch = 8'h6C;
          3'd3: ch = 8'h6C;
          default: ch = 8'h00;
        endcase
      end
      MODE_TRUE: begin
        case (pos)
          3'd0: ch = 8'h74;
          3'd1: ch = 8'h72;
          3'd2: ch = 8'h75;
          3'd3: ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      MODE_FALSE: begin
        case (pos)
          3'd0: ch = 8'h66;
          3'd1: ch = 8'h61;
          3'd2: ch = 8'h6C;
          3'd3: ch = 8'h73;
          3'd4: ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Position of a keyword's last character
  function automatic logic [2:0] kw_last(input logic [2:0] kind);
    return (kind == MODE_FALSE) ? 3'd4 : 3'd3;
  endfunction

  function automatic logic is_syntax(input logic [7:0] c);
    return (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_LBRACE) ||
           (c == CH_RBRACE) || (c == CH_COLON) || (c == CH_COMMA);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== src/json_token_lexer.sv =====
// A result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; in_ready is high while the output register is empty
//   or drains in the same cycle, so only a stalled consumer slows the stream.
// Reset (rst_n low, synchronous): lexer returns to idle, counters clear, output empties.
// Top level of the streaming JSON token lexer; uses jtl_pkg, jtl_step, jtl_out_stage
//   and the assertion macros in json_token_lexer_assert.svh.
`include "json_token_lexer_assert.svh"

module json_token_lexer (
  input  logic        clk,
  input  logic        rst_n,
  // input request channel: one byte of JSON text per request
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic        in_start_req,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_text,
  // result request channel: one result per input request
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_value_valid,
  output logic [7:0]  out_value_byte,
  output logic        out_consumed,
  output logic        out_token_end,
  output logic [15:0] out_token_length,
  output logic [2:0]  out_status
);

  // Lexer state: phase, token kind, keyword match position, \u skip count,
  // digit flag and saturating byte count of the current token.
  jtl_pkg::lex_state_t  st_r;
  jtl_pkg::lex_state_t  st_nxt;
  jtl_pkg::lex_result_t res_nxt;
  jtl_pkg::lex_result_t res_q;
  logic                 space;
  logic                 in_fire;

  assign in_ready = space;
  assign in_fire  = in_valid && space;

  // Per-byte decision logic: takes the state register and the request,
  // gives the next state and the result for this byte.
  jtl_step u_step (
    .cur_i   (st_r),
    .mode_i  (in_mode),
    .start_i (in_start_req),
    .byte_i  (in_data_byte),
    .eot_i   (in_end_of_text),
    .nxt_o   (st_nxt),
    .res_o   (res_nxt)
  );

  // State advances only on an accepted request; it and the result register
  // load on the same edge, so they always describe the same byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= jtl_pkg::PH_IDLE;
      st_r.kind       <= 3'd0;
      st_r.kw_pos     <= 3'd0;
      st_r.uni_left   <= 3'd0;
      st_r.digit_seen <= 1'b0;
      st_r.len        <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // Output register decouples the consumer's ready from new requests
  jtl_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (in_fire),
    .res_i     (res_nxt),
    .space_o   (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_o     (res_q)
  );

  assign out_value_valid  = res_q.value_valid;
  assign out_value_byte   = res_q.value_byte;
  assign out_consumed     = res_q.consumed;
  assign out_token_end    = res_q.token_end;
  assign out_token_length = res_q.token_length;
  assign out_status       = res_q.status;

  // A held token-end result means the lexer is back at idle
  `JTL_ASSERT_NOW(a_end_idle, out_valid && out_token_end, st_r.phase == jtl_pkg::PH_IDLE,
                  "token end shown while lexer not idle")
  // A consumed byte that does not end the token leaves a token open
  `JTL_ASSERT_NOW(a_open_token, out_valid && out_consumed && !out_token_end,
                  st_r.phase != jtl_pkg::PH_IDLE, "open token lost its phase")
  // Emitting a value character always consumes the byte
  `JTL_ASSERT_NOW(a_emit_cons, out_valid && out_value_valid, out_consumed,
                  "value byte emitted without consuming input")
  // Start together with end of text ends an empty token at once
  `JTL_ASSERT_NEXT(a_start_eot, in_fire && in_start_req && in_end_of_text,
                   out_valid && out_token_end && out_token_length == 16'd0,
                   "start at end of text did not close an empty token")

endmodule

// ===== src/jtl_step.sv =====
// Next-state and result logic of the lexer for one input byte.
// Depends on jtl_pkg.
module jtl_step (
  input  jtl_pkg::lex_state_t  cur_i,
  input  logic [2:0]           mode_i,
  input  logic                 start_i,
  input  logic [7:0]           byte_i,
  input  logic                 eot_i,
  output jtl_pkg::lex_state_t  nxt_o,
  output jtl_pkg::lex_result_t res_o
);

  always_comb begin
    jtl_pkg::lex_state_t s;
    jtl_pkg::phase_t     p;
    logic       take;
    logic       emit;
    logic [7:0] vb;
    logic       fin;
    logic [2:0] stat;
    logic       esc_ok;
    logic [7:0] esc_val;

    s       = cur_i;
    p       = jtl_pkg::PH_IDLE;
    take    = 1'b0;
    emit    = 1'b0;
    vb      = 8'h00;
    fin     = 1'b0;
    stat    = jtl_pkg::ST_OK;
    esc_ok  = 1'b1;
    esc_val = 8'h00;

    if (start_i) begin
      s.kind       = mode_i;
      s.len        = '0;
      s.kw_pos     = 3'd0;
      s.uni_left   = 3'd0;
      s.digit_seen = 1'b0;
      case (mode_i)
        jtl_pkg::MODE_STRING: s.phase = jtl_pkg::PH_STR_OPEN;
        jtl_pkg::MODE_NUMBER: s.phase = jtl_pkg::PH_NUM_START;
        jtl_pkg::MODE_SYNTAX: s.phase = jtl_pkg::PH_SYNTAX;
        jtl_pkg::MODE_NULL,
        jtl_pkg::MODE_TRUE,
        jtl_pkg::MODE_FALSE:  s.phase = jtl_pkg::PH_KEYWORD;
        default: begin
          s.phase = jtl_pkg::PH_IDLE;
          fin     = 1'b1;
          stat    = jtl_pkg::ST_NO_MATCH;
        end
      endcase
      if (eot_i && !fin) begin
        s.phase = jtl_pkg::PH_IDLE;
        fin     = 1'b1;
        stat    = jtl_pkg::ST_NO_MATCH;
      end
    end

    if (!fin && s.phase != jtl_pkg::PH_IDLE) begin
      if (eot_i) begin
        fin = 1'b1;
        unique case (s.phase)
          jtl_pkg::PH_STR_BODY: stat = jtl_pkg::ST_UNTERM;
          jtl_pkg::PH_STR_ESC:  stat = jtl_pkg::ST_EOF_ESC;
          jtl_pkg::PH_STR_UHEX,
          jtl_pkg::PH_STR_UEND: stat = jtl_pkg::ST_SHORT_UNI;
          jtl_pkg::PH_NUM_START, jtl_pkg::PH_NUM_INT, jtl_pkg::PH_NUM_FRAC,
          jtl_pkg::PH_NUM_EXPS, jtl_pkg::PH_NUM_EXPD:
            stat = s.digit_seen ? jtl_pkg::ST_OK : jtl_pkg::ST_NO_MATCH;
          jtl_pkg::PH_KEYWORD:
            stat = (s.kw_pos != 3'd0) ? jtl_pkg::ST_KW_PARTIAL : jtl_pkg::ST_NO_MATCH;
          default: stat = jtl_pkg::ST_NO_MATCH;
        endcase
        s.phase = jtl_pkg::PH_IDLE;
      end else begin
        unique case (s.phase)
          jtl_pkg::PH_SYNTAX: begin
            fin = 1'b1;
            if (jtl_pkg::is_syntax(byte_i)) begin
              take = 1'b1;
              emit = 1'b1;
              vb   = byte_i;
              stat = jtl_pkg::ST_OK;
            end else begin
              stat = jtl_pkg::ST_NO_MATCH;
            end
            s.phase = jtl_pkg::PH_IDLE;
          end

          jtl_pkg::PH_KEYWORD: begin
            if (byte_i == jtl_pkg::kw_char(s.kind, s.kw_pos)) begin
              take = 1'b1;
              emit = 1'b1;
              vb   = byte_i;
              if (s.kw_pos == jtl_pkg::kw_last(s.kind)) begin
                fin     = 1'b1;
                stat    = jtl_pkg::ST_OK;
                s.phase = jtl_pkg::PH_IDLE;
              end
              s.kw_pos = s.kw_pos + 3'd1;
            end else begin
              fin     = 1'b1;
              stat    = (s.kw_pos != 3'd0) ? jtl_pkg::ST_KW_PARTIAL : jtl_pkg::ST_NO_MATCH;
              s.phase = jtl_pkg::PH_IDLE;
            end
          end

          jtl_pkg::PH_NUM_START, jtl_pkg::PH_NUM_INT, jtl_pkg::PH_NUM_FRAC,
          jtl_pkg::PH_NUM_EXPS, jtl_pkg::PH_NUM_EXPD: begin
            // A leading minus sign only counts at the very first byte
            p = (s.phase == jtl_pkg::PH_NUM_START) ? jtl_pkg::PH_NUM_INT : s.phase;
            priority if (s.phase == jtl_pkg::PH_NUM_START && byte_i == jtl_pkg::CH_MINUS) begin
              take    = 1'b1;
              s.phase = jtl_pkg::PH_NUM_INT;
            end else if (jtl_pkg::is_digit(byte_i)) begin
              take         = 1'b1;
              s.phase      = (p == jtl_pkg::PH_NUM_EXPS) ? jtl_pkg::PH_NUM_EXPD : p;
              s.digit_seen = 1'b1;
            end else if (p == jtl_pkg::PH_NUM_INT && byte_i == jtl_pkg::CH_DOT) begin
              take    = 1'b1;
              s.phase = jtl_pkg::PH_NUM_FRAC;
            end else if ((p == jtl_pkg::PH_NUM_INT || p == jtl_pkg::PH_NUM_FRAC) &&
                         (byte_i == jtl_pkg::CH_LOW_E || byte_i == jtl_pkg::CH_UP_E)) begin
              take    = 1'b1;
              s.phase = jtl_pkg::PH_NUM_EXPS;
            end else if (p == jtl_pkg::PH_NUM_EXPS &&
                         (byte_i == jtl_pkg::CH_PLUS || byte_i == jtl_pkg::CH_MINUS)) begin
              take    = 1'b1;
              s.phase = jtl_pkg::PH_NUM_EXPD;
            end else begin
              fin     = 1'b1;
              stat    = s.digit_seen ? jtl_pkg::ST_OK : jtl_pkg::ST_NO_MATCH;
              s.phase = jtl_pkg::PH_IDLE;
            end
            emit = take;
            vb   = byte_i;
          end

          jtl_pkg::PH_STR_OPEN: begin
            if (byte_i == jtl_pkg::CH_QUOTE) begin
              take    = 1'b1;
              s.phase = jtl_pkg::PH_STR_BODY;
            end else begin
              fin     = 1'b1;
              stat    = jtl_pkg::ST_NO_MATCH;
              s.phase = jtl_pkg::PH_IDLE;
            end
          end

          jtl_pkg::PH_STR_ESC: begin
            case (byte_i)
              jtl_pkg::CH_QUOTE:  esc_val = jtl_pkg::CH_QUOTE;
              jtl_pkg::CH_BSLASH: esc_val = jtl_pkg::CH_BSLASH;
              jtl_pkg::CH_SLASH:  esc_val = jtl_pkg::CH_SLASH;
              jtl_pkg::CH_LOW_B:  esc_val = jtl_pkg::CH_BS;
              jtl_pkg::CH_LOW_F:  esc_val = jtl_pkg::CH_FF;
              jtl_pkg::CH_LOW_N:  esc_val = jtl_pkg::CH_LF;
              jtl_pkg::CH_LOW_R:  esc_val = jtl_pkg::CH_CR;
              jtl_pkg::CH_LOW_T:  esc_val = jtl_pkg::CH_TAB;
              default:            esc_ok  = 1'b0;
            endcase
            if (byte_i == jtl_pkg::CH_LOW_U) begin
              // \u: swallow the next four bytes unchecked, emit nothing
              take       = 1'b1;
              s.uni_left = jtl_pkg::UNI_SKIP;
              s.phase    = jtl_pkg::PH_STR_UHEX;
            end else if (esc_ok) begin
              take    = 1'b1;
              emit    = 1'b1;
              vb      = esc_val;
              s.phase = jtl_pkg::PH_STR_BODY;
            end else begin
              fin     = 1'b1;
              stat    = jtl_pkg::ST_BAD_ESC;
              s.phase = jtl_pkg::PH_IDLE;
            end
          end

          jtl_pkg::PH_STR_UHEX: begin
            take = 1'b1;
            if (s.uni_left == 3'd1) begin
              s.phase = jtl_pkg::PH_STR_UEND;
            end
            s.uni_left = s.uni_left - 3'd1;
          end

          jtl_pkg::PH_STR_BODY, jtl_pkg::PH_STR_UEND: begin
            take = 1'b1;
            priority if (byte_i == jtl_pkg::CH_QUOTE) begin
              fin     = 1'b1;
              stat    = jtl_pkg::ST_OK;
              s.phase = jtl_pkg::PH_IDLE;
            end else if (byte_i == jtl_pkg::CH_BSLASH) begin
              s.phase = jtl_pkg::PH_STR_ESC;
            end else begin
              emit    = 1'b1;
              vb      = byte_i;
              s.phase = jtl_pkg::PH_STR_BODY;
            end
          end

          default: begin
            s.phase = jtl_pkg::PH_IDLE;
          end
        endcase
      end
    end

    // Saturating byte count
    if (take && (s.len != {jtl_pkg::LEN_W{1'b1}})) begin
      s.len = s.len + 1'b1;
    end

    nxt_o                    = s;
    res_o.value_valid        = emit;
    res_o.value_byte         = emit ? vb : 8'h00;
    res_o.consumed           = take;
    res_o.token_end          = fin;
    res_o.token_length       = (start_i || fin || take) ? s.len : '0;
    res_o.status             = fin ? stat : jtl_pkg::ST_OK;
  end

endmodule

// ===== src/jtl_out_stage.sv =====
// Result register with valid/ready handshake toward the consumer.
// Depends on jtl_pkg.
module jtl_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_i,
  input  jtl_pkg::lex_result_t res_i,
  output logic                 space_o,
  output logic                 out_valid,
  input  logic                 out_ready,
  output jtl_pkg::lex_result_t res_o
);

  logic                 valid_r;
  jtl_pkg::lex_result_t res_r;

  // Room when empty or when the held request leaves this cycle
  assign space_o   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_o     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_i) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for json_token_lexer: a directed table and random token
// streams, checked against a behavioral lexer kept in step or hand-typed results.
// Depends on jtl_pkg and the json_token_lexer RTL.
module tb;
  import jtl_pkg::*;

  // Modes outside the six token kinds
  localparam logic [2:0] MODE_BAD_LO = 3'd6;
  localparam logic [2:0] MODE_BAD_HI = 3'd7;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Q = 8'h71;

  localparam int RAND_REQS   = 1520;
  localparam int STALL_LIMIT = 2000;
  localparam int DIRECTED_N  = 29;

  // Keywords left-aligned, one byte per character, first character on top
  localparam logic [39:0] KW_WORDS [3] = '{{"null", 8'h00}, {"true", 8'h00}, "false"};
  localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B,
                                            CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T};
  localparam logic [7:0] SYNTAX_CHARS [6] = '{CH_LBRACK, CH_RBRACK, CH_LBRACE,
                                             CH_RBRACE, CH_COLON, CH_COMMA};
  localparam logic [7:0] NUM_ENDS [4] = '{CH_COMMA, CH_RBRACK, CH_RBRACE, CH_SPACE};

  localparam lex_result_t ZERO_RES     = '0;
  localparam lex_result_t NO_MATCH_RES = '{1'b0, 8'h00, 1'b0, 1'b1, 16'd0, ST_NO_MATCH};
  localparam lex_result_t BRACE_RES    = '{1'b1, CH_LBRACE, 1'b1, 1'b1, 16'd1, ST_OK};

  // One input request; fixed marks a row whose result is typed in by hand
  typedef struct {
    logic [2:0]  mode;
    logic        start;
    logic [7:0]  data;
    logic        eot;
    logic        fixed;
    lex_result_t want;
  } lex_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_mode = '0;
  logic        in_start_req = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_value_valid;
  logic [7:0]  out_value_byte;
  logic        out_consumed;
  logic        out_token_end;
  logic [15:0] out_token_length;
  logic [2:0]  out_status;

  json_token_lexer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_start_req     (in_start_req),
    .in_data_byte     (in_data_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value_valid  (out_value_valid),
    .out_value_byte   (out_value_byte),
    .out_consumed     (out_consumed),
    .out_token_end    (out_token_end),
    .out_token_length (out_token_length),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  // Lexer state mirrored by the predictor
  phase_t      tok_phase = PH_IDLE;
  logic [2:0]  tok_kind = '0;
  logic [2:0]  kw_idx = '0;
  logic [2:0]  hex_left = '0;
  logic        saw_digit = 1'b0;
  logic [15:0] tok_len = '0;
  lex_result_t cur_result;

  lex_result_t byte_results_q [$];   // one expected result per accepted request, in order
  lex_req_t    stim_q [$];
  lex_req_t    drv_req;              // request currently on the input pins
  int          mismatches = 0;
  int          stall_cycles = 0;
  logic        idle_on = 1'b1;       // random gaps and stalls enabled

  lex_req_t directed_reqs [DIRECTED_N] = '{
    // idle: a byte without start, then end of text, both give an all-zero result
    '{MODE_STRING, 1'b0, 8'hFF,     1'b0, 1'b1, ZERO_RES},
    '{MODE_FALSE,  1'b0, 8'h00,     1'b1, 1'b1, ZERO_RES},
    // unknown modes end at once, nothing consumed
    '{MODE_BAD_HI, 1'b1, CH_QUOTE,  1'b0, 1'b1, NO_MATCH_RES},
    '{MODE_BAD_LO, 1'b1, CH_LOW_N,  1'b0, 1'b1, NO_MATCH_RES},
    // start together with end of text
    '{MODE_STRING, 1'b1, CH_QUOTE,  1'b1, 1'b1, NO_MATCH_RES},
    // syntax: a good one, then a stray byte
    '{MODE_SYNTAX, 1'b1, CH_LBRACE, 1'b0, 1'b1, BRACE_RES},
    '{MODE_SYNTAX, 1'b1, CH_QUOTE,  1'b0, 1'b1, NO_MATCH_RES},
    // string without its opening quote
    '{MODE_STRING, 1'b1, CH_LOW_N,  1'b0, 1'b1, NO_MATCH_RES},
    // string cut off inside a \u escape
    '{MODE_STRING, 1'b1, CH_QUOTE,  1'b0, 1'b0, ZERO_RES},
    '{MODE_NUMBER, 1'b0, CH_BSLASH, 1'b0, 1'b0, ZERO_RES},
    '{MODE_BAD_HI, 1'b0, CH_LOW_U,  1'b0, 1'b0, ZERO_RES},
    '{MODE_STRING, 1'b0, CH_NINE,   1'b0, 1'b0, ZERO_RES},
    '{MODE_STRING, 1'b0, 8'h00,     1'b1, 1'b0, ZERO_RES},
    // bad escape
    '{MODE_STRING, 1'b1, CH_QUOTE,  1'b0, 1'b0, ZERO_RES},
    '{MODE_STRING, 1'b0, CH_BSLASH, 1'b0, 1'b0, ZERO_RES},
    '{MODE_STRING, 1'b0, CH_LOW_Q,  1'b0, 1'b0, ZERO_RES},
    // keyword partly matched, then a wrong character
    '{MODE_NULL,   1'b1, CH_LOW_N,  1'b0, 1'b0, ZERO_RES},
    '{MODE_NULL,   1'b0, CH_LOW_U,  1'b0, 1'b0, ZERO_RES},
    '{MODE_NULL,   1'b0, CH_LOW_E,  1'b0, 1'b0, ZERO_RES},
    // true abandoned by a new start, false cut by end of text
    '{MODE_TRUE,   1'b1, CH_LOW_T,  1'b0, 1'b0, ZERO_RES},
    '{MODE_FALSE,  1'b1, CH_LOW_F,  1'b0, 1'b0, ZERO_RES},
    '{MODE_TRUE,   1'b0, CH_LOW_A,  1'b0, 1'b0, ZERO_RES},
    '{MODE_FALSE,  1'b0, 8'hFF,     1'b1, 1'b0, ZERO_RES},
    // number with sign, integer part and exponent, closed by a byte it does not take
    '{MODE_NUMBER, 1'b1, CH_MINUS,  1'b0, 1'b0, ZERO_RES},
    '{MODE_NUMBER, 1'b0, CH_NINE,   1'b0, 1'b0, ZERO_RES},
    '{MODE_NUMBER, 1'b0, CH_UP_E,   1'b0, 1'b0, ZERO_RES},
    '{MODE_NUMBER, 1'b0, CH_PLUS,   1'b0, 1'b0, ZERO_RES},
    '{MODE_NUMBER, 1'b0, CH_ZERO,   1'b0, 1'b0, ZERO_RES},
    '{MODE_NUMBER, 1'b0, CH_COMMA,  1'b0, 1'b0, ZERO_RES}
  };

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void take_byte(input logic [7:0] c, input logic emit);
    cur_result.consumed = 1'b1;
    if (tok_len != 16'hFFFF) tok_len = tok_len + 16'd1;  // saturates
    if (emit) begin
      cur_result.value_valid = 1'b1;
      cur_result.value_byte  = c;
    end
  endfunction

  function automatic void end_token(input logic [2:0] st);
    cur_result.token_end = 1'b1;
    cur_result.status    = st;
    tok_phase            = PH_IDLE;
  endfunction

  // Expected lexer output for one accepted request; advances the mirrored state
  function automatic lex_result_t lex_next(input logic [2:0] mode, input logic start,
                                           input logic [7:0] c, input logic eot);
    logic [7:0] esc;
    logic       esc_ok;
    logic [2:0] kw_len;
    cur_result = '0;
    if (start) begin
      tok_kind  = mode;
      tok_len   = '0;
      kw_idx    = '0;
      hex_left  = '0;
      saw_digit = 1'b0;
      case (mode)
        MODE_STRING: tok_phase = PH_STR_OPEN;
        MODE_NUMBER: tok_phase = PH_NUM_START;
        MODE_SYNTAX: tok_phase = PH_SYNTAX;
        MODE_NULL, MODE_TRUE, MODE_FALSE: tok_phase = PH_KEYWORD;
        default: end_token(ST_NO_MATCH);
      endcase
      if (eot && !cur_result.token_end) end_token(ST_NO_MATCH);
    end

    if (!cur_result.token_end && tok_phase != PH_IDLE) begin
      if (eot) begin
        case (tok_phase)
          PH_STR_BODY: end_token(ST_UNTERM);
          PH_STR_ESC:  end_token(ST_EOF_ESC);
          PH_STR_UHEX, PH_STR_UEND: end_token(ST_SHORT_UNI);
          PH_NUM_START, PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXPS, PH_NUM_EXPD:
            end_token(saw_digit ? ST_OK : ST_NO_MATCH);
          PH_KEYWORD: end_token(kw_idx != 3'd0 ? ST_KW_PARTIAL : ST_NO_MATCH);
          default: end_token(ST_NO_MATCH);
        endcase
      end else begin
        case (tok_phase)
          PH_SYNTAX: begin
            if (c inside {CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_COLON, CH_COMMA})
            begin
              take_byte(c, 1'b1);
              end_token(ST_OK);
            end else begin
              end_token(ST_NO_MATCH);
            end
          end
          PH_KEYWORD: begin
            kw_len = (tok_kind == MODE_FALSE) ? 3'd5 : 3'd4;
            if (kw_idx < kw_len &&
                c == KW_WORDS[tok_kind - MODE_NULL][39 - 8 * int'(kw_idx) -: 8]) begin
              take_byte(c, 1'b1);
              kw_idx = kw_idx + 3'd1;
              if (kw_idx == kw_len) end_token(ST_OK);
            end else begin
              end_token(kw_idx != 3'd0 ? ST_KW_PARTIAL : ST_NO_MATCH);
            end
          end
          PH_NUM_START, PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXPS, PH_NUM_EXPD: begin
            if (tok_phase == PH_NUM_START && c == CH_MINUS) begin
              take_byte(c, 1'b1);
              tok_phase = PH_NUM_INT;
            end else begin
              // no sign: the first byte is judged as if in the integer part
              if (tok_phase == PH_NUM_START) tok_phase = PH_NUM_INT;
              if (c >= CH_ZERO && c <= CH_NINE) begin
                take_byte(c, 1'b1);
                if (tok_phase == PH_NUM_EXPS) tok_phase = PH_NUM_EXPD;
                saw_digit = 1'b1;
              end else if (tok_phase == PH_NUM_INT && c == CH_DOT) begin
                take_byte(c, 1'b1);
                tok_phase = PH_NUM_FRAC;
              end else if ((tok_phase == PH_NUM_INT || tok_phase == PH_NUM_FRAC) &&
                           (c == CH_LOW_E || c == CH_UP_E)) begin
                take_byte(c, 1'b1);
                tok_phase = PH_NUM_EXPS;
              end else if (tok_phase == PH_NUM_EXPS && (c == CH_PLUS || c == CH_MINUS)) begin
                take_byte(c, 1'b1);
                tok_phase = PH_NUM_EXPD;
              end else begin
                end_token(saw_digit ? ST_OK : ST_NO_MATCH);
              end
            end
          end
          PH_STR_OPEN: begin
            if (c == CH_QUOTE) begin
              take_byte(c, 1'b0);
              tok_phase = PH_STR_BODY;
            end else begin
              end_token(ST_NO_MATCH);
            end
          end
          PH_STR_ESC: begin
            if (c == CH_LOW_U) begin
              take_byte(c, 1'b0);
              hex_left  = UNI_SKIP;
              tok_phase = PH_STR_UHEX;
            end else begin
              esc    = 8'h00;
              esc_ok = 1'b1;
              case (c)
                CH_QUOTE:  esc = CH_QUOTE;
                CH_BSLASH: esc = CH_BSLASH;
                CH_SLASH:  esc = CH_SLASH;
                CH_LOW_B:  esc = CH_BS;
                CH_LOW_F:  esc = CH_FF;
                CH_LOW_N:  esc = CH_LF;
                CH_LOW_R:  esc = CH_CR;
                CH_LOW_T:  esc = CH_TAB;
                default:   esc_ok = 1'b0;
              endcase
              if (esc_ok) begin
                take_byte(esc, 1'b1);
                tok_phase = PH_STR_BODY;
              end else begin
                end_token(ST_BAD_ESC);
              end
            end
          end
          PH_STR_UHEX: begin
            // the four bytes after \u are swallowed whatever they are
            take_byte(c, 1'b0);
            hex_left = hex_left - 3'd1;
            if (hex_left == 3'd0) tok_phase = PH_STR_UEND;
          end
          default: begin
            // string body, or body right after a \u escape
            if (c == CH_QUOTE) begin
              take_byte(c, 1'b0);
              end_token(ST_OK);
            end else if (c == CH_BSLASH) begin
              take_byte(c, 1'b0);
              tok_phase = PH_STR_ESC;
            end else begin
              take_byte(c, 1'b1);
              tok_phase = PH_STR_BODY;
            end
          end
        endcase
      end
    end

    // length is shown only on requests that start, end or extend a token
    cur_result.token_length =
      (start || cur_result.token_end || cur_result.consumed) ? tok_len : 16'd0;
    return cur_result;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic void add_req(input logic [2:0] mode, input logic start,
                                  input logic [7:0] data, input logic eot);
    lex_req_t r;
    r = '{mode, start, data, eot, 1'b0, ZERO_RES};
    stim_q.push_back(r);
  endfunction

  // A body byte that neither closes the string nor opens an escape
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    return (c == CH_QUOTE || c == CH_BSLASH) ? CH_LOW_E : c;
  endfunction

  // Appends one mostly well-formed token, sometimes corrupted or cut by end of text,
  // or a burst of raw noise
  function automatic void build_token();
    logic [7:0] body [$];
    logic [2:0] kind;
    int         pick;
    int         cut;
    int         kw_n;
    pick = $urandom_range(9);
    kind = MODE_STRING;
    case (pick)
      0, 1, 2: begin
        body.push_back(CH_QUOTE);
        repeat ($urandom_range(6)) begin
          if ($urandom_range(4) != 0) begin
            body.push_back(plain_char());
          end else begin
            body.push_back(CH_BSLASH);
            case ($urandom_range(9))
              8: begin
                body.push_back(CH_LOW_U);
                repeat (4) body.push_back(8'($urandom_range(255)));
              end
              9: body.push_back(8'($urandom_range(255)));  // mostly a bad escape
              default: body.push_back(ESC_LETTERS[$urandom_range(7)]);
            endcase
          end
        end
        body.push_back(CH_QUOTE);
      end
      3, 4: begin
        kind = MODE_NUMBER;
        if ($urandom_range(1) != 0) body.push_back(CH_MINUS);
        repeat ($urandom_range(3)) body.push_back(8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(1) != 0) begin
          body.push_back(CH_DOT);
          repeat ($urandom_range(2)) body.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
        if ($urandom_range(2) == 0) begin
          body.push_back(($urandom_range(1) != 0) ? CH_LOW_E : CH_UP_E);
          case ($urandom_range(2))
            0: body.push_back(CH_PLUS);
            1: body.push_back(CH_MINUS);
            default: ;
          endcase
          repeat ($urandom_range(2)) body.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
        body.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255)) :
                       NUM_ENDS[$urandom_range(3)]);
      end
      5: begin
        kind = MODE_SYNTAX;
        body.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255)) :
                       SYNTAX_CHARS[$urandom_range(5)]);
      end
      6, 7, 8: begin
        kind = 3'(MODE_NULL + $urandom_range(2));
        kw_n = (kind == MODE_FALSE) ? 5 : 4;
        for (int i = 0; i < kw_n; i++)
          body.push_back(KW_WORDS[kind - MODE_NULL][39 - 8 * i -: 8]);
        if ($urandom_range(4) == 0) body[$urandom_range(kw_n - 1)] = 8'($urandom_range(255));
      end
      default: begin
        repeat ($urandom_range(1, 4))
          add_req(3'($urandom_range(7)), $urandom_range(3) == 0, 8'($urandom_range(255)),
                  $urandom_range(7) == 0);
        return;
      end
    endcase

    // now and then end of text lands somewhere inside the token
    cut = ($urandom_range(7) == 0) ? $urandom_range(body.size()) : -1;
    foreach (body[i])
      if (cut < 0 || i < cut)
        add_req((i == 0) ? kind : 3'($urandom_range(7)), i == 0, body[i], 1'b0);
    if (cut >= 0)
      add_req((cut == 0) ? kind : 3'($urandom_range(7)), cut == 0,
              8'($urandom_range(255)), 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic push_req(input lex_req_t r);
    if (idle_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    drv_req        = r;
    in_valid       <= 1'b1;
    in_mode        <= r.mode;
    in_start_req   <= r.start;
    in_data_byte   <= r.data;
    in_end_of_text <= r.eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every pending result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (byte_results_q.size() != 0) @(negedge clk);
  endtask

  // Receiver: ready drops with a chance of about one in ten while idling is on
  always @(negedge clk)
    out_ready <= !idle_on || ($urandom_range(99) >= 10);

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted request, compare on each accepted result
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    lex_result_t want;
    lex_result_t predicted;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (byte_results_q.size() == 0) begin
          $error("result with no request pending");
          mismatches++;
        end else begin
          want = byte_results_q.pop_front();
          check_field("value_valid",  16'(want.value_valid),  16'(out_value_valid));
          check_field("value_byte",   16'(want.value_byte),   16'(out_value_byte));
          check_field("consumed",     16'(want.consumed),     16'(out_consumed));
          check_field("token_end",    16'(want.token_end),    16'(out_token_end));
          check_field("token_length", want.token_length,      out_token_length);
          check_field("status",       16'(want.status),       16'(out_status));
        end
      end
      if (in_valid && in_ready) begin
        // the predictor always runs so its state tracks the block
        predicted = lex_next(in_mode, in_start_req, in_data_byte, in_end_of_text);
        byte_results_q.push_back(drv_req.fixed ? drv_req.want : predicted);
      end
    end
  end

  // Watchdog: too long with nothing moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_reqs[i]) push_req(directed_reqs[i]);
    drain();

    // random token streams, with a stretch that runs flat out on both sides
    while (stim_q.size() < RAND_REQS) build_token();
    foreach (stim_q[i]) begin
      idle_on = !(i >= 400 && i < 900);
      push_req(stim_q[i]);
    end
    idle_on = 1'b1;
    drain();

    // let anything stray show up before closing
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/jtl_pkg.sv
src/jtl_step.sv
src/jtl_out_stage.sv
src/json_token_lexer.sv
verif/tb.sv
